[hw/rtl/sbl_pkg.sv]
// Shared definitions for the S-expression byte lexer: event kinds, character
// codes, the push control bundle and default widths. Used by every RTL file.
`default_nettype none

package sbl_pkg;

    localparam int LINE_BITS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;

    // Result queue: four slots, so one item that makes two events still fits
    // while the consumer drains one slot per cycle.
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_DEPTH    = 1 << QUEUE_PTR_BITS;

    localparam logic [3:0] KIND_LPAREN    = 4'd0;
    localparam logic [3:0] KIND_RPAREN    = 4'd1;
    localparam logic [3:0] KIND_ATOM_BYTE = 4'd2;
    localparam logic [3:0] KIND_ATOM_END  = 4'd3;
    localparam logic [3:0] KIND_STR_OPEN  = 4'd4;
    localparam logic [3:0] KIND_STR_BYTE  = 4'd5;
    localparam logic [3:0] KIND_STR_CLOSE = 4'd6;
    localparam logic [3:0] KIND_UNTERM    = 4'd7;
    localparam logic [3:0] KIND_END       = 4'd8;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_VTAB      = 8'h0B;
    localparam logic [7:0] CH_FORMFEED  = 8'h0C;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;

    typedef struct packed {
        logic push0;
        logic push1;
    } sbl_push_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_NEWLINE) || (c == CH_CR) ||
               (c == CH_TAB) || (c == CH_VTAB) || (c == CH_FORMFEED);
    endfunction

    function automatic logic [7:0] decode_escape(input logic [7:0] c);
        logic [7:0] d;
        d = c;
        if (c == CH_LOWER_N) begin
            d = CH_NEWLINE;
        end else if (c == CH_LOWER_R) begin
            d = CH_CR;
        end else if (c == CH_LOWER_T) begin
            d = CH_TAB;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sbl_lex_core.sv]
// Lexer state and event decode: mode, position counters and token start,
// and up to two events per accepted byte. Depends on sbl_pkg.
`default_nettype none

module sbl_lex_core
    import sbl_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    localparam int EVT_W      = 4 + 8 + LINE_BITS + COLUMN_BITS + 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic             op,
    input  wire logic [7:0]       in_byte,
    output logic      [EVT_W-1:0] ev0,
    output logic      [EVT_W-1:0] ev1,
    output sbl_push_t             push
);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_ATOM    = 3'd2;
    localparam logic [2:0] MODE_STRING  = 3'd3;
    localparam logic [2:0] MODE_ESCAPE  = 3'd4;

    localparam logic [LINE_BITS-1:0]   LINE_ONE   = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COLUMN_ONE = COLUMN_BITS'(1);

    logic [2:0]             mode_reg,  mode_next;
    logic [LINE_BITS-1:0]   line_reg,  line_next;
    logic [COLUMN_BITS-1:0] col_reg,   col_next;
    logic [LINE_BITS-1:0]   sline_reg, sline_next;
    logic [COLUMN_BITS-1:0] scol_reg,  scol_next;

    logic [LINE_BITS-1:0]   line_adv;
    logic [COLUMN_BITS-1:0] col_adv;

    // Token start decode for the current byte.
    logic       ts_emit;
    logic [3:0] ts_kind;
    logic [7:0] ts_value;
    logic       ts_first;
    logic       ts_set_start;
    logic [2:0] ts_mode;

    logic                   e0_on, e1_on;
    logic [3:0]             k0, k1;
    logic [7:0]             v0;
    logic [LINE_BITS-1:0]   l0, l1;
    logic [COLUMN_BITS-1:0] c0, c1;
    logic                   f0;

    always_comb begin
        if (in_byte == CH_NEWLINE) begin
            line_adv = (&line_reg) ? line_reg : line_reg + LINE_ONE;
            col_adv  = COLUMN_ONE;
        end else begin
            line_adv = line_reg;
            col_adv  = (&col_reg) ? col_reg : col_reg + COLUMN_ONE;
        end
    end

    always_comb begin
        ts_emit      = 1'b0;
        ts_kind      = KIND_LPAREN;
        ts_value     = 8'd0;
        ts_first     = 1'b0;
        ts_set_start = 1'b0;
        ts_mode      = MODE_IDLE;
        if (is_blank(in_byte)) begin
            ts_mode = MODE_IDLE;
        end else if (in_byte == CH_SEMICOLON || in_byte == CH_HASH) begin
            ts_mode = MODE_COMMENT;
        end else if (in_byte == CH_LPAREN) begin
            ts_emit = 1'b1;
            ts_kind = KIND_LPAREN;
        end else if (in_byte == CH_RPAREN) begin
            ts_emit = 1'b1;
            ts_kind = KIND_RPAREN;
        end else if (in_byte == CH_QUOTE) begin
            ts_emit      = 1'b1;
            ts_kind      = KIND_STR_OPEN;
            ts_set_start = 1'b1;
            ts_mode      = MODE_STRING;
        end else begin
            ts_emit      = 1'b1;
            ts_kind      = KIND_ATOM_BYTE;
            ts_value     = in_byte;
            ts_first     = 1'b1;
            ts_set_start = 1'b1;
            ts_mode      = MODE_ATOM;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        e0_on = 1'b0;
        e1_on = 1'b0;
        k0 = KIND_END;
        v0 = 8'd0;
        l0 = sline_reg;
        c0 = scol_reg;
        f0 = 1'b0;
        k1 = KIND_END;
        l1 = line_reg;
        c1 = col_reg;

        if (op) begin
            // End of text: close what is open, report the end, then start over.
            if (mode_reg == MODE_ATOM) begin
                e0_on = 1'b1;
                e1_on = 1'b1;
                k0    = KIND_ATOM_END;
            end else if (mode_reg == MODE_STRING || mode_reg == MODE_ESCAPE) begin
                e0_on = 1'b1;
                e1_on = 1'b1;
                k0    = KIND_UNTERM;
            end else begin
                e0_on = 1'b1;
                k0    = KIND_END;
                l0    = line_reg;
                c0    = col_reg;
            end
            mode_next  = MODE_IDLE;
            line_next  = LINE_ONE;
            col_next   = COLUMN_ONE;
            sline_next = LINE_ONE;
            scol_next  = COLUMN_ONE;
        end else begin
            line_next = line_adv;
            col_next  = col_adv;
            case (mode_reg)
                MODE_COMMENT: begin
                    if (in_byte == CH_NEWLINE) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_ATOM: begin
                    if (is_blank(in_byte) || in_byte == CH_LPAREN ||
                        in_byte == CH_RPAREN) begin
                        // The delimiter closes the atom and may itself be a paren.
                        e0_on     = 1'b1;
                        k0        = KIND_ATOM_END;
                        e1_on     = ts_emit;
                        k1        = ts_kind;
                        mode_next = ts_mode;
                    end else begin
                        e0_on = 1'b1;
                        k0    = KIND_ATOM_BYTE;
                        v0    = in_byte;
                    end
                end
                MODE_STRING: begin
                    if (in_byte == CH_BACKSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end else if (in_byte == CH_QUOTE) begin
                        e0_on     = 1'b1;
                        k0        = KIND_STR_CLOSE;
                        mode_next = MODE_IDLE;
                    end else begin
                        e0_on = 1'b1;
                        k0    = KIND_STR_BYTE;
                        v0    = in_byte;
                    end
                end
                MODE_ESCAPE: begin
                    e0_on     = 1'b1;
                    k0        = KIND_STR_BYTE;
                    v0        = decode_escape(in_byte);
                    mode_next = MODE_STRING;
                end
                default: begin
                    e0_on     = ts_emit;
                    k0        = ts_kind;
                    v0        = ts_value;
                    f0        = ts_first;
                    l0        = line_reg;
                    c0        = col_reg;
                    mode_next = ts_mode;
                    if (ts_set_start) begin
                        sline_next = line_reg;
                        scol_next  = col_reg;
                    end
                end
            endcase
        end
    end

    // When both events are present ev1 is always the second of the pair.
    always_comb begin
        push.push0 = accept && (e0_on || e1_on);
        push.push1 = accept && e0_on && e1_on;
        ev0 = {!e1_on, f0, c0, l0, v0, k0};
        ev1 = {1'b1, 1'b0, c1, l1, 8'd0, k1};
        if (!e0_on) begin
            ev0 = {1'b1, 1'b0, c1, l1, 8'd0, k1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            line_reg  <= LINE_ONE;
            col_reg   <= COLUMN_ONE;
            sline_reg <= LINE_ONE;
            scol_reg  <= COLUMN_ONE;
        end else if (accept) begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sbl_evt_queue.sv]
// Result queue: a small register file that takes up to two events per cycle
// and hands out one per cycle while out_ready is high. Depends on sbl_pkg.
`default_nettype none

module sbl_evt_queue
    import sbl_pkg::*;
#(
    parameter int EVT_W = 48,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire sbl_push_t        push,
    input  wire logic [EVT_W-1:0] ev0,
    input  wire logic [EVT_W-1:0] ev1,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [EVT_W-1:0] out_evt,
    output logic      [CNT_W-1:0] level
);

    logic [EVT_W-1:0]          slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_inc;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      pop;

    assign wr_ptr_inc = wr_ptr_reg + QUEUE_PTR_BITS'(1);
    assign pop        = out_valid && out_ready;
    assign out_valid  = (count_reg != '0);
    assign out_evt    = slots_reg[rd_ptr_reg];
    assign level      = count_reg;
    // Room for a full two-event request is required before taking a byte.
    assign in_ready   = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));

    always_comb begin
        count_next  = count_reg + CNT_W'(push.push0) + CNT_W'(push.push1)
                      - CNT_W'(pop);
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_BITS'(push.push0)
                      + QUEUE_PTR_BITS'(push.push1);
    end

    always_ff @(posedge aclk) begin
        if (push.push0) begin
            slots_reg[wr_ptr_reg] <= ev0;
        end
        if (push.push1) begin
            slots_reg[wr_ptr_inc] <= ev1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sexp_byte_lexer.sv]
// Channel  Ports        tdata (low bit up)                     tuser   tlast
// s_       s_t*         in_byte                                op      -
// m_       m_t*         value, line, column, first atom byte,  kind    last_of_run
//                       zero pad to whole bytes
//
// One byte is taken per cycle while s_tready is high; the byte's events are written
// into a four-slot result queue in the same cycle and leave one per cycle on the m_
// side while m_tready is high. A byte that makes two events leaves the queue one
// fuller even while m_ drains, and s_tready drops once fewer than two slots are free.
// aresetn is synchronous and active low; it empties the queue and returns the
// lexer to line one, column one. Stalls on m_ back up into s_tready only.
`default_nettype none

module sexp_byte_lexer
    import sbl_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    localparam int EVT_W      = 4 + 8 + LINE_BITS + COLUMN_BITS + 2,
    localparam int DATA_BITS  = 8 + LINE_BITS + COLUMN_BITS + 1,
    localparam int TDATA_W    = ((DATA_BITS + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // in_byte
    input  wire logic               s_tuser,   // op
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [TDATA_W-1:0] m_tdata,   // value, line, column, first atom byte
    output logic      [3:0]         m_tuser,   // kind
    output logic                    m_tlast
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             s_accept;
    logic [EVT_W-1:0] ev0, ev1, out_evt;
    sbl_push_t        push;
    logic [CNT_W-1:0] level;

    assign s_accept = s_tvalid && s_tready;

    sbl_lex_core #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .op      (s_tuser),
        .in_byte (s_tdata),
        .ev0     (ev0),
        .ev1     (ev1),
        .push    (push)
    );

    sbl_evt_queue #(
        .EVT_W (EVT_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .ev0       (ev0),
        .ev1       (ev1),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_evt   (out_evt),
        .level     (level)
    );

    // Event layout, low bit up: kind, value, line, column, first, last.
    assign m_tuser = out_evt[3:0];
    assign m_tlast = out_evt[EVT_W-1];
    assign m_tdata = TDATA_W'(out_evt[EVT_W-2:4]);

`ifndef ASSERT_OFF
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue level beyond its depth");

    a_end_gives_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser |=> m_tvalid)
        else $error("end of text request left no event");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_END |-> m_tlast)
        else $error("end event not marked last");

    a_first_on_atom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[DATA_BITS-1] |-> m_tuser == KIND_ATOM_BYTE)
        else $error("token start flag on a non atom event");
`endif

endmodule

`default_nettype wire

[tb/sexp_byte_lexer_tb.sv]
// Self-checking testbench for sexp_byte_lexer: directed token and end-of-text
// tests, then random S-expression text under random stalls.
// Depends on sbl_pkg for the event kinds and character codes.
module sexp_byte_lexer_tb;
    import sbl_pkg::*;

    localparam int LINE_W      = LINE_BITS_DEF;
    localparam int COL_W       = COLUMN_BITS_DEF;
    localparam int TDATA_W     = ((8 + LINE_W + COL_W + 1 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 20;
    localparam int MAX_GAP     = 13;

    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_COMMENT,
        LX_ATOM,
        LX_STRING,
        LX_ESCAPE
    } lex_mode_t;

    typedef struct packed {
        logic [3:0]       kind;
        logic [7:0]       value;
        logic [LINE_W-1:0] tok_line;
        logic [COL_W-1:0]  tok_col;
        logic             first;
        logic             last;
    } lex_event_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [3:0]         m_tuser;
    logic               m_tlast;

    // Lexer tracking state, kept in step with accepted requests.
    lex_mode_t         lx_mode;
    logic [LINE_W-1:0] cur_line;
    logic [COL_W-1:0]  cur_col;
    logic [LINE_W-1:0] tok_line;
    logic [COL_W-1:0]  tok_col;

    lex_event_t pending_events[$];
    lex_event_t staged_ev[2];
    int         staged_n;

    int errors      = 0;
    int sent_items  = 0;
    int cycle_count = 0;
    bit src_idle    = 1'b1;
    bit snk_idle    = 1'b1;

    sexp_byte_lexer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit is_gap_byte(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_NEWLINE, CH_CR, CH_TAB, CH_VTAB, CH_FORMFEED: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] pick_atom_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_gap_byte(c) || c == CH_LPAREN || c == CH_RPAREN) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    task automatic clear_tracker();
        lx_mode  = LX_IDLE;
        cur_line = LINE_W'(1);
        cur_col  = COL_W'(1);
        tok_line = LINE_W'(1);
        tok_col  = COL_W'(1);
    endtask

    task automatic stage_event(input logic [3:0] kind, input logic [7:0] value,
                               input logic [LINE_W-1:0] ln, input logic [COL_W-1:0] col,
                               input logic first);
        staged_ev[staged_n] = {kind, value, ln, col, first, 1'b0};
        staged_n++;
    endtask

    // Both counters stop at all ones instead of wrapping.
    task automatic step_position(input logic [7:0] c);
        if (c == CH_NEWLINE) begin
            if (cur_line != '1) cur_line++;
            cur_col = COL_W'(1);
        end else if (cur_col != '1) begin
            cur_col++;
        end
    endtask

    task automatic start_token(input logic [7:0] c);
        if (is_gap_byte(c)) begin
        end else if (c == CH_SEMICOLON || c == CH_HASH) begin
            lx_mode = LX_COMMENT;
        end else if (c == CH_LPAREN) begin
            stage_event(KIND_LPAREN, 8'h00, cur_line, cur_col, 1'b0);
        end else if (c == CH_RPAREN) begin
            stage_event(KIND_RPAREN, 8'h00, cur_line, cur_col, 1'b0);
        end else if (c == CH_QUOTE) begin
            tok_line = cur_line;
            tok_col  = cur_col;
            stage_event(KIND_STR_OPEN, 8'h00, tok_line, tok_col, 1'b0);
            lx_mode = LX_STRING;
        end else begin
            tok_line = cur_line;
            tok_col  = cur_col;
            stage_event(KIND_ATOM_BYTE, c, tok_line, tok_col, 1'b1);
            lx_mode = LX_ATOM;
        end
        step_position(c);
    endtask

    task automatic predict_events(input logic op, input logic [7:0] c);
        lex_event_t ev;
        logic [7:0] d;
        staged_n = 0;
        if (op == OP_END) begin
            if (lx_mode == LX_ATOM) begin
                stage_event(KIND_ATOM_END, 8'h00, tok_line, tok_col, 1'b0);
            end else if (lx_mode == LX_STRING || lx_mode == LX_ESCAPE) begin
                stage_event(KIND_UNTERM, 8'h00, tok_line, tok_col, 1'b0);
            end
            stage_event(KIND_END, 8'h00, cur_line, cur_col, 1'b0);
            clear_tracker();
        end else begin
            case (lx_mode)
                LX_COMMENT: begin
                    if (c == CH_NEWLINE) lx_mode = LX_IDLE;
                    step_position(c);
                end
                LX_ATOM: begin
                    // A delimiter closes the atom and is then lexed afresh.
                    if (is_gap_byte(c) || c == CH_LPAREN || c == CH_RPAREN) begin
                        stage_event(KIND_ATOM_END, 8'h00, tok_line, tok_col, 1'b0);
                        lx_mode = LX_IDLE;
                        start_token(c);
                    end else begin
                        stage_event(KIND_ATOM_BYTE, c, tok_line, tok_col, 1'b0);
                        step_position(c);
                    end
                end
                LX_STRING: begin
                    step_position(c);
                    if (c == CH_BACKSLASH) begin
                        lx_mode = LX_ESCAPE;
                    end else if (c == CH_QUOTE) begin
                        stage_event(KIND_STR_CLOSE, 8'h00, tok_line, tok_col, 1'b0);
                        lx_mode = LX_IDLE;
                    end else begin
                        stage_event(KIND_STR_BYTE, c, tok_line, tok_col, 1'b0);
                    end
                end
                LX_ESCAPE: begin
                    step_position(c);
                    case (c)
                        CH_LOWER_N: d = CH_NEWLINE;
                        CH_LOWER_R: d = CH_CR;
                        CH_LOWER_T: d = CH_TAB;
                        default:    d = c;
                    endcase
                    stage_event(KIND_STR_BYTE, d, tok_line, tok_col, 1'b0);
                    lx_mode = LX_STRING;
                end
                default: begin
                    lx_mode = LX_IDLE;
                    start_token(c);
                end
            endcase
        end
        for (int i = 0; i < staged_n; i++) begin
            ev = staged_ev[i];
            ev.last = (i == staged_n - 1);
            pending_events = {pending_events, ev};
        end
    endtask

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            errors++;
        end
    endtask

    task automatic check_event();
        lex_event_t want;
        if (pending_events.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d value %0h",
                     $time, m_tuser, m_tdata[7:0]);
            errors++;
        end else begin
            want = pending_events.pop_front();
            check_field("kind", want.kind, m_tuser);
            check_field("value", want.value, m_tdata[7:0]);
            check_field("start line", want.tok_line, m_tdata[8 +: LINE_W]);
            check_field("start column", want.tok_col, m_tdata[8 + LINE_W +: COL_W]);
            check_field("starts_token", want.first, m_tdata[8 + LINE_W + COL_W]);
            check_field("last_of_run", want.last, m_tlast);
        end
    endtask

    // Requests and results are both sampled at the rising edge, request first.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_events(s_tuser, s_tdata);
            if (m_tvalid && m_tready) check_event();
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: a random stall before each result is taken, while snk_idle is set.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // s_tvalid stays high between back-to-back requests and only drops for a gap.
    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(OP_TEXT, s[i]);
    endtask

    task automatic test_directed_tokens();
        send_text("( ab)\"x\\n\\q\\\"\"");
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_TEXT, 8'h00);
        send_text("#;\"\t");
        send_text(";c\n#\n");
        send_item(OP_TEXT, CH_CR);
        send_item(OP_TEXT, CH_VTAB);
        send_item(OP_TEXT, CH_FORMFEED);
        send_text("\"\\r\\t");
        send_item(OP_TEXT, CH_QUOTE);
        send_item(OP_END, 8'h00);
    endtask

    task automatic test_end_of_text();
        send_text("\"\\");
        send_item(OP_END, 8'h5A);
        send_text("\"a");
        send_item(OP_END, 8'h00);
        send_text("zz");
        send_item(OP_END, 8'hA5);
        send_item(OP_END, 8'hFF);
        send_text("(");
        send_item(OP_END, 8'h00);
    endtask

    task automatic test_random_text();
        int         goal;
        int         len;
        int         pick;
        logic [7:0] c;
        goal = sent_items + 2000;
        while (sent_items < goal) begin
            if ($urandom_range(0, 39) == 0) begin
                src_idle = $urandom_range(0, 2) != 0;
                snk_idle = $urandom_range(0, 2) != 0;
            end
            pick = $urandom_range(0, 99);
            len  = $urandom_range(1, 6);
            if (pick < 15) begin
                send_item(OP_TEXT, CH_LPAREN);
            end else if (pick < 30) begin
                send_item(OP_TEXT, CH_RPAREN);
            end else if (pick < 50) begin
                repeat (len) send_item(OP_TEXT, pick_atom_byte());
            end else if (pick < 65) begin
                send_item(OP_TEXT, CH_QUOTE);
                repeat (len) begin
                    if ($urandom_range(0, 3) == 0) begin
                        case ($urandom_range(0, 4))
                            0:       c = CH_LOWER_N;
                            1:       c = CH_LOWER_R;
                            2:       c = CH_LOWER_T;
                            3:       c = CH_QUOTE;
                            default: c = 8'($urandom_range(0, 255));
                        endcase
                        send_item(OP_TEXT, CH_BACKSLASH);
                        send_item(OP_TEXT, c);
                    end else begin
                        c = 8'($urandom_range(0, 255));
                        while (c == CH_QUOTE || c == CH_BACKSLASH) c = 8'($urandom_range(0, 255));
                        send_item(OP_TEXT, c);
                    end
                end
                // Now and then the string is left open to run into later text.
                if ($urandom_range(0, 9) != 0) send_item(OP_TEXT, CH_QUOTE);
            end else if (pick < 72) begin
                send_item(OP_TEXT, $urandom_range(0, 1) ? CH_SEMICOLON : CH_HASH);
                repeat (len) begin
                    c = 8'($urandom_range(0, 255));
                    while (c == CH_NEWLINE) c = 8'($urandom_range(0, 255));
                    send_item(OP_TEXT, c);
                end
                send_item(OP_TEXT, CH_NEWLINE);
            end else if (pick < 90) begin
                case ($urandom_range(0, 5))
                    0:       c = CH_SPACE;
                    1:       c = CH_NEWLINE;
                    2:       c = CH_CR;
                    3:       c = CH_TAB;
                    4:       c = CH_VTAB;
                    default: c = CH_FORMFEED;
                endcase
                send_item(OP_TEXT, c);
            end else if (pick < 97) begin
                send_item(OP_TEXT, 8'($urandom_range(0, 255)));
            end else begin
                send_item(OP_END, 8'($urandom_range(0, 255)));
            end
        end
        send_item(OP_END, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        clear_tracker();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = OP_TEXT;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_tokens();
        test_end_of_text();
        test_random_text();

        s_tvalid <= 1'b0;
        // Let the clock advance so the last request has surely been predicted.
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
